@@ hw/rtl/ddo_pkg.sv @@
`default_nettype none
package ddo_pkg;

  localparam int SineDepth = 1024;
  localparam int SineIdxW = $clog2(SineDepth);
  localparam int PosFracBits = 8;
  localparam int SpdW = 24;
  localparam logic [63:0] SinePiHalfQ30 = 64'd1686629713;

  typedef enum logic [1:0] {
    MODE_UPDATE = 2'd0,
    MODE_SET    = 2'd1,
    MODE_RESET  = 2'd2,
    MODE_HOLD   = 2'd3
  } mode_t;

  localparam logic [1:0] REG_ANGLE_GAIN = 2'd0;
  localparam logic [1:0] REG_LEFT_RATIO = 2'd1;
  localparam logic [1:0] REG_RIGHT_RATIO = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] ticks_right;
    logic signed [31:0] ticks_left;
    logic [31:0]        time_us;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic [15:0]        new_heading;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic signed [23:0] enc_speed_right;
    logic signed [23:0] enc_speed_left;
    logic signed [23:0] motor_speed_right;
    logic signed [23:0] motor_speed_left;
    logic signed [23:0] motor_acc_right;
    logic signed [23:0] motor_acc_left;
    logic               time_fault;
  } out_item_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic        neg;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    else if (v < -64'sd8388608) return 24'sh800000;
    else return v[23:0];
  endfunction

  // shift-subtract division, only used to build the sine rom contents
  function automatic logic [63:0] const_udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q, rm;
    q = '0;
    rm = '0;
    for (int b = 63; b >= 0; b--) begin
      rm = {rm[62:0], n[b]};
      if (rm >= d) begin
        rm = rm - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // 16384 * sin(pi/2 * r / depth), fixed-point taylor series in q30
  function automatic logic signed [15:0] quarter_sine(input logic [63:0] r);
    logic [63:0] x, x2, term, pos, neg;
    x = (SinePiHalfQ30 * r) >> SineIdxW;
    x2 = (x * x) >> 30;
    term = x;
    pos = x;
    neg = '0;
    for (int k = 1; k <= 8; k++) begin
      term = const_udiv((term * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
      if (k[0]) neg = neg + term;
      else pos = pos + term;
    end
    pos = (pos > neg) ? pos - neg : '0;
    return 16'((pos * 64'd16384 + 64'd536870912) >> 30);
  endfunction

  // full-turn table entry built from the quarter wave
  function automatic logic signed [15:0] sine_entry(input int i);
    logic [63:0] n, q, r;
    logic signed [15:0] v;
    n = 64'(i) << 2;
    q = n >> SineIdxW;
    r = n & 64'(SineDepth - 1);
    v = q[0] ? quarter_sine(64'(SineDepth) - r) : quarter_sine(r);
    return q[1] ? -v : v;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ddo_div.sv @@
`default_nettype none
module ddo_div
  import ddo_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire div_req_t    req,
  output logic             done,
  output logic signed [63:0] quot
);
  // restoring divider, one quotient bit per cycle, truncates toward zero
  logic [63:0] q;
  logic [32:0] rem;
  logic [6:0]  cnt;
  logic        busy, neg;
  logic [31:0] dvs;
  logic [32:0] trial;

  assign trial = {rem[31:0], q[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        q    <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
        neg  <= req.neg;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[31:0], q[63]};
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? -$signed(q) : $signed(q);
endmodule
`default_nettype wire

@@ hw/rtl/differential_drive_odometry.sv @@
`default_nettype none
// differential drive odometry
// in channel: in_valid/in_stall with in_data (in_item_t); out channel:
// out_valid/out_stall with out_data (out_item_t). config: cfg_we, cfg_index,
// cfg_data, must be written only while no item is in flight (not enforced).
// an update item runs four 64-bit divisions on one shared restoring divider
// (encoder speeds, then accelerations) and five steps on one shared
// multiplier (motor blend, heading, x and y). an update with zero elapsed
// time skips the divisions and the motor blend; set, reset and hold items
// skip all arithmetic.
// one item at a time: in_stall is high from accept until its result has been
// taken, and the next item can be accepted in the cycle after that.
// the result sits in the state registers; while out_stall is high it holds
// and no new item is accepted.
// reset clears pose, previous ticks and time, speeds and config to defaults;
// the block is ready in the cycle after reset drops. the sine table is a
// constant rom filled at start.
module differential_drive_odometry
  import ddo_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_DELTA = 14'b00000000000010,
    S_DIVER = 14'b00000000000100,
    S_DIVEL = 14'b00000000001000,
    S_MOTR  = 14'b00000000010000,
    S_MOTL  = 14'b00000000100000,
    S_DIVAR = 14'b00000001000000,
    S_DIVAL = 14'b00000010000000,
    S_ANG   = 14'b00000100000000,
    S_TRIG  = 14'b00001000000000,
    S_POSX  = 14'b00010000000000,
    S_POSY  = 14'b00100000000000,
    S_OUT   = 14'b01000000000000,
    S_WAIT  = 14'b10000000000000
  } state_t;

  state_t state;
  logic [31:0] angle_gain;
  logic signed [17:0] left_ratio, right_ratio;
  logic [31:0] pose_x, pose_y, prev_r, prev_l, prev_time;
  logic [15:0] pose_heading;
  logic signed [23:0] spd_er, spd_el, spd_mr, spd_ml;
  logic signed [23:0] new_er, new_el, new_mr, new_ml, acc_r, acc_l;
  logic fault;
  in_item_t item;
  logic [31:0] dt;
  logic signed [31:0] dr, dl;
  logic signed [32:0] dsum;
  logic signed [24:0] ediff;
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] mul_p;
  logic signed [15:0] sine_rom [SineDepth];
  logic [SineIdxW-1:0] sin_addr, cos_addr;
  logic signed [15:0] sin_q, cos_q;
  div_req_t dreq;
  logic ddone;
  logic signed [63:0] dquot;

  ddo_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quot(dquot));

  function automatic div_req_t mk_req(input logic signed [63:0] n, input logic [31:0] d);
    div_req_t r;
    r.start = 1'b1;
    r.neg = n[63];
    r.dividend = n[63] ? 64'(-n) : 64'(n);
    r.divisor = d;
    return r;
  endfunction

  assign in_stall = (state != S_IDLE);

  always_comb begin
    dreq = '0;
    case (state)
      S_DELTA: if (item.mode == MODE_UPDATE && dt != '0) dreq = mk_req(64'(dr) * 64'sd1000, dt);
      S_DIVER: if (ddone) dreq = mk_req(64'(dl) * 64'sd1000, dt);
      S_MOTL: dreq = mk_req(64'(new_mr) - 64'(spd_mr), dt);
      S_DIVAR: if (ddone) dreq = mk_req(64'(new_ml) - 64'(spd_ml), dt);
      default: dreq = '0;
    endcase
  end

  // shared multiplier, operands picked by state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MOTR: begin
        mul_a = 34'(ediff);
        mul_b = 33'(right_ratio);
      end
      S_MOTL: begin
        mul_a = 34'(ediff);
        mul_b = 33'(left_ratio);
      end
      S_ANG: begin
        mul_a = 34'(dr) - 34'(dl);
        mul_b = {1'b0, angle_gain};
      end
      S_POSX: begin
        mul_a = 34'(dsum);
        mul_b = 33'(cos_q);
      end
      S_POSY: begin
        mul_a = 34'(dsum);
        mul_b = 33'(sin_q);
      end
      default: ;
    endcase
  end

  assign mul_p = 67'(mul_a) * 67'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      angle_gain <= 32'd65536;
      left_ratio <= 18'sd0;
      right_ratio <= 18'sd65536;
      pose_x <= '0; pose_y <= '0; pose_heading <= '0;
      prev_r <= '0; prev_l <= '0; prev_time <= '0;
      spd_er <= '0; spd_el <= '0; spd_mr <= '0; spd_ml <= '0;
      acc_r <= '0; acc_l <= '0; fault <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ANGLE_GAIN:  angle_gain <= cfg_data;
          REG_LEFT_RATIO:  left_ratio <= cfg_data[17:0];
          REG_RIGHT_RATIO: right_ratio <= cfg_data[17:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_valid) begin
          item <= in_data;
          acc_r <= '0; acc_l <= '0; fault <= 1'b0;
          state <= S_DELTA;
        end
        S_DELTA: begin
          case (mode_t'(item.mode))
            MODE_UPDATE: begin
              fault <= (dt == '0);
              state <= (dt == '0) ? S_ANG : S_DIVER;
            end
            MODE_SET: begin
              pose_x <= item.new_x; pose_y <= item.new_y;
              pose_heading <= item.new_heading;
              state <= S_OUT;
            end
            MODE_RESET: begin
              pose_x <= '0; pose_y <= '0; pose_heading <= '0;
              spd_er <= '0; spd_el <= '0; spd_mr <= '0; spd_ml <= '0;
              prev_r <= item.ticks_right; prev_l <= item.ticks_left;
              state <= S_OUT;
            end
            default: state <= S_OUT;
          endcase
        end
        S_DIVER: if (ddone) begin
          new_er <= sat24(dquot);
          state <= S_DIVEL;
        end
        S_DIVEL: if (ddone) begin
          new_el <= sat24(dquot);
          state <= S_MOTR;
        end
        S_MOTR: begin
          new_mr <= sat24(64'(new_el) + 64'(mul_p >>> 16));
          state <= S_MOTL;
        end
        S_MOTL: begin
          new_ml <= sat24(64'(new_el) + 64'(mul_p >>> 16));
          state <= S_DIVAR;
        end
        S_DIVAR: if (ddone) begin
          acc_r <= sat24(dquot);
          state <= S_DIVAL;
        end
        S_DIVAL: if (ddone) begin
          acc_l <= sat24(dquot);
          spd_er <= new_er; spd_el <= new_el;
          spd_mr <= new_mr; spd_ml <= new_ml;
          state <= S_ANG;
        end
        S_ANG: begin
          pose_heading <= pose_heading + mul_p[31:16];
          state <= S_TRIG;
        end
        // rom reads the new heading here
        S_TRIG: state <= S_POSX;
        S_POSX: begin
          pose_x <= pose_x + 32'(mul_p >>> (15 - PosFracBits));
          state <= S_POSY;
        end
        S_POSY: begin
          pose_y <= pose_y + 32'(mul_p >>> (15 - PosFracBits));
          prev_time <= item.time_us;
          prev_r <= item.ticks_right; prev_l <= item.ticks_left;
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  initial begin
    for (int i = 0; i < SineDepth; i++) sine_rom[i] = sine_entry(i);
  end

  always_ff @(posedge clk) begin
    sin_q <= sine_rom[sin_addr];
    cos_q <= sine_rom[cos_addr];
  end

  assign dt = item.time_us - prev_time;
  assign dr = signed'(item.ticks_right - prev_r);
  assign dl = signed'(item.ticks_left - prev_l);
  assign dsum = 33'(dr) + 33'(dl);
  assign ediff = 25'(new_er) - 25'(new_el);
  assign sin_addr = SineIdxW'((32'(pose_heading) * SineDepth) >> 16);
  assign cos_addr = SineIdxW'((32'(16'(pose_heading + 16'd16384)) * SineDepth) >> 16);

  always_comb begin
    out_data.pos_x = pose_x;
    out_data.pos_y = pose_y;
    out_data.heading = pose_heading;
    out_data.enc_speed_right = spd_er;
    out_data.enc_speed_left = spd_el;
    out_data.motor_speed_right = spd_mr;
    out_data.motor_speed_left = spd_ml;
    out_data.motor_acc_right = acc_r;
    out_data.motor_acc_left = acc_l;
    out_data.time_fault = fault;
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> !in_stall)
    else $error("stall while idle");
  assert property (@(posedge clk) disable iff (rst) fault |-> acc_r == '0 && acc_l == '0)
    else $error("acceleration with time fault");
endmodule
`default_nettype wire

@@ test/odometry_checker.sv @@
module odometry_checker
  import ddo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam longint SpeedMax = 64'sd8388607;
  localparam longint SpeedMin = -64'sd8388608;

  logic [31:0] gain;
  logic [17:0] ratio_l, ratio_r;
  logic [31:0] x_now, y_now, prev_r, prev_l, prev_t;
  logic [15:0] hdg;
  longint      enc_r, enc_l, mot_r, mot_l;
  logic signed [15:0] sine_tab [SineDepth];
  out_item_t   expected_q[$];

  // quarter wave by fixed-point taylor series, q30
  function automatic longint quarter_sine_ref(longint unsigned r);
    longint unsigned x, x2, term, pos, neg;
    x = 64'd1686629713 * r / 64'(SineDepth);
    x2 = (x * x) >> 30;
    term = x;
    pos = x;
    neg = 0;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    pos = (pos > neg) ? pos - neg : 64'd0;
    return longint'((pos * 64'd16384 + (64'd1 << 29)) >> 30);
  endfunction

  initial begin
    longint unsigned n, q, r;
    longint v;
    for (int i = 0; i < SineDepth; i++) begin
      n = 64'(4 * i);
      q = n / 64'(SineDepth);
      r = n % 64'(SineDepth);
      v = q[0] ? quarter_sine_ref(64'(SineDepth) - r) : quarter_sine_ref(r);
      sine_tab[i] = 16'(q[1] ? -v : v);
    end
  end

  function automatic longint clamp_speed(longint v);
    return v > SpeedMax ? SpeedMax : (v < SpeedMin ? SpeedMin : v);
  endfunction

  function automatic longint blend_motor(longint er, longint el, logic [17:0] ratio);
    longint w;
    w = longint'($signed(ratio));
    return clamp_speed(el + (((er - el) * w) >>> 16));
  endfunction

  // position step: sum * trig, floor-shifted down to the pose fraction
  function automatic logic [31:0] pose_step(longint sum, logic [15:0] angle);
    longint p;
    p = sum * longint'(sine_tab[angle[15:6]]);
    return 32'(p >>> (15 - PosFracBits));
  endfunction

  function automatic out_item_t advance_odometry(in_item_t it);
    out_item_t r;
    logic [31:0] dt;
    logic [63:0] prod;
    longint dr, dl, dtl, er, el, mr, ml, ar, al;
    logic fault;
    ar = 0;
    al = 0;
    fault = 1'b0;
    case (mode_t'(it.mode))
      MODE_UPDATE: begin
        dt = it.time_us - prev_t;
        dr = longint'($signed(it.ticks_right - prev_r));
        dl = longint'($signed(it.ticks_left - prev_l));
        if (dt == 0) begin
          fault = 1'b1;
        end else begin
          dtl = longint'({32'b0, dt});
          er = clamp_speed(dr * 1000 / dtl);
          el = clamp_speed(dl * 1000 / dtl);
          mr = blend_motor(er, el, ratio_r);
          ml = blend_motor(er, el, ratio_l);
          ar = clamp_speed((mr - mot_r) / dtl);
          al = clamp_speed((ml - mot_l) / dtl);
          enc_r = er; enc_l = el; mot_r = mr; mot_l = ml;
        end
        prod = 64'(dr - dl) * {32'b0, gain};
        hdg = hdg + prod[31:16];
        x_now = x_now + pose_step(dr + dl, hdg + 16'd16384);
        y_now = y_now + pose_step(dr + dl, hdg);
        prev_t = it.time_us;
        prev_r = it.ticks_right;
        prev_l = it.ticks_left;
      end
      MODE_SET: begin
        x_now = it.new_x;
        y_now = it.new_y;
        hdg = it.new_heading;
      end
      MODE_RESET: begin
        x_now = '0; y_now = '0; hdg = '0;
        enc_r = 0; enc_l = 0; mot_r = 0; mot_l = 0;
        prev_r = it.ticks_right;
        prev_l = it.ticks_left;
      end
      default: ;
    endcase
    r.pos_x = x_now;
    r.pos_y = y_now;
    r.heading = hdg;
    r.enc_speed_right = 24'(enc_r);
    r.enc_speed_left = 24'(enc_l);
    r.motor_speed_right = 24'(mot_r);
    r.motor_speed_left = 24'(mot_l);
    r.motor_acc_right = 24'(ar);
    r.motor_acc_left = 24'(al);
    r.time_fault = fault;
    return r;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      gain <= 32'd65536; ratio_l <= '0; ratio_r <= 18'd65536;
      x_now <= '0; y_now <= '0; hdg <= '0;
      prev_r <= '0; prev_l <= '0; prev_t <= '0;
      enc_r <= 0; enc_l <= 0; mot_r <= 0; mot_l <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ANGLE_GAIN:  gain = cfg_data;
          REG_LEFT_RATIO:  ratio_l = cfg_data[17:0];
          REG_RIGHT_RATIO: ratio_r = cfg_data[17:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_q.push_back(advance_odometry(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          check_field("pos_x", e.pos_x, out_data.pos_x);
          check_field("pos_y", e.pos_y, out_data.pos_y);
          check_field("heading", e.heading, out_data.heading);
          check_field("enc_speed_right", e.enc_speed_right, out_data.enc_speed_right);
          check_field("enc_speed_left", e.enc_speed_left, out_data.enc_speed_left);
          check_field("motor_speed_right", e.motor_speed_right, out_data.motor_speed_right);
          check_field("motor_speed_left", e.motor_speed_left, out_data.motor_speed_left);
          check_field("motor_acc_right", e.motor_acc_right, out_data.motor_acc_right);
          check_field("motor_acc_left", e.motor_acc_left, out_data.motor_acc_left);
          check_field("time_fault", e.time_fault, out_data.time_fault);
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

@@ test/testbench.sv @@
module testbench;
  import ddo_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_ANGLE_GAIN;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  logic        quiet = 1'b0;
  logic        stim_done = 1'b0;

  logic signed [31:0] enc_r_abs = 0, enc_l_abs = 0;
  logic [31:0]        clock_us = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  differential_drive_odometry dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  odometry_checker checker_i (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending
  );

  // receiver stalls in bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_motion(logic signed [31:0] d_r, logic signed [31:0] d_l,
                             logic [31:0] d_t);
    in_item_t it;
    enc_r_abs += d_r;
    enc_l_abs += d_l;
    clock_us += d_t;
    it = '0;
    it.new_x = $urandom;
    it.new_y = $urandom;
    it.new_heading = 16'($urandom);
    it.mode = MODE_UPDATE;
    it.ticks_right = enc_r_abs;
    it.ticks_left = enc_l_abs;
    it.time_us = clock_us;
    send_item(it);
  endtask

  task automatic send_pose(mode_t m, logic [31:0] x, logic [31:0] y, logic [15:0] h);
    in_item_t it;
    it.mode = m;
    it.ticks_right = $urandom;
    it.ticks_left = $urandom;
    it.time_us = $urandom;
    it.new_x = x;
    it.new_y = y;
    it.new_heading = h;
    if (m == MODE_RESET) begin
      enc_r_abs = it.ticks_right;
      enc_l_abs = it.ticks_left;
    end
    send_item(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_item;
    int pick;
    logic signed [31:0] span;
    pick = $urandom_range(0, 99);
    span = ($urandom_range(0, 9) == 0) ? 32'sh7FFFFFFF : 32'sd2000;
    if (pick < 80) begin
      send_motion($signed($urandom) % span, $signed($urandom) % span,
                  ($urandom_range(0, 19) == 0) ? 32'(0) :
                  ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 5000));
    end else if (pick < 87) begin
      send_pose(MODE_SET, $urandom, $urandom, 16'($urandom));
    end else if (pick < 93) begin
      send_pose(MODE_RESET, 0, 0, 16'd0);
    end else if (pick < 97) begin
      send_pose(MODE_HOLD, $urandom, $urandom, 16'($urandom));
    end else begin
      clock_us = $urandom;
      send_motion($urandom, $urandom, 0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults first
    send_motion(100, 100, 1000);
    send_motion(50, -50, 1000);
    send_motion(10, 10, 0);
    send_motion(32'sh7FFFFFFF, 32'sh80000000, 1);
    send_motion(-32'sd5000, 32'sd5000, 32'hFFFFFFFF);
    send_motion(1, 0, 32'hFFFFFFF0);
    send_pose(MODE_SET, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF);
    send_motion(200, 300, 700);
    send_pose(MODE_SET, 32'h80000000, 32'h7FFFFFFF, 16'h4000);
    send_motion(-300, -200, 3);
    send_pose(MODE_HOLD, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
    send_pose(MODE_RESET, 0, 0, 16'd0);
    send_motion(40, 20, 2);
    send_motion(0, 0, 5);
    drain();

    write_reg(REG_ANGLE_GAIN, 32'hFFFFFFFF);
    write_reg(REG_LEFT_RATIO, 32'(-131072));
    write_reg(REG_RIGHT_RATIO, 32'd131071);
    send_motion(1000, -1000, 10);
    send_motion(32'sh7FFFFFFF, 32'sh80000000, 1);
    send_motion(-7, 3, 1);
    send_motion(5, 5, 0);
    send_pose(MODE_SET, 32'h12345678, 32'h9ABCDEF0, 16'h8000);
    send_motion(123, 456, 789);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_ANGLE_GAIN, 32'd0);
          write_reg(REG_LEFT_RATIO, 32'd131071);
          write_reg(REG_RIGHT_RATIO, 32'(-131072));
        end
        1: begin
          write_reg(REG_ANGLE_GAIN, $urandom);
          write_reg(REG_LEFT_RATIO, $urandom);
          write_reg(REG_RIGHT_RATIO, $urandom);
        end
        2: begin
          write_reg(REG_ANGLE_GAIN, $urandom_range(0, 32'h00040000));
          write_reg(REG_LEFT_RATIO, 32'd32768);
          write_reg(REG_RIGHT_RATIO, 32'd98304);
        end
        default: begin
          write_reg(REG_ANGLE_GAIN, 32'd65536);
          write_reg(REG_LEFT_RATIO, 32'd0);
          write_reg(REG_RIGHT_RATIO, 32'd65536);
        end
      endcase
      if (phase == 3) quiet <= 1'b1;
      for (int n = 0; n < 150; n++) random_item();
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Verification failed");
    $finish;
  end

endmodule
